// File: sv/apfb_pkg.sv
`default_nettype none
package apfb_pkg;

  localparam logic [3:0] ARP_LAST_IDX   = 4'd5;
  localparam logic [3:0] NS_LAST_IDX    = 4'd9;
  localparam logic [3:0] FULL_BYTES     = 4'd8;
  localparam logic [3:0] ARP_LAST_BYTES = 4'd2;
  localparam logic [3:0] NS_LAST_BYTES  = 4'd6;

  localparam logic CMD_ARP = 1'b0;
  localparam logic CMD_NS  = 1'b1;

  // constant part of the NS checksum: ff02, 0001, ff00, 8700, length 24, next header 58
  localparam logic [19:0] NS_CK_BASE = 20'h28555;

  typedef struct packed {
    logic        cmd;
    logic [63:0] hi;
    logic [63:0] lo;
  } apfb_req_t;

  typedef struct packed {
    apfb_req_t   req;
    logic [15:0] ck;
  } apfb_frame_t;

endpackage
`default_nettype wire

// File: sv/apfb_csum_pipe.sv
`default_nettype none
module apfb_csum_pipe import apfb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire apfb_req_t   in_req,
  output logic             in_ready,
  output logic             out_valid,
  output apfb_frame_t      out_frame,
  input  wire logic        out_ready
);

  logic        v1, v2, v3;
  logic        rdy1, rdy2, rdy3;
  apfb_req_t   r1, r2, r3;
  logic [17:0] sa;
  logic [18:0] sb;
  logic [19:0] tot;
  logic [15:0] ck;
  logic [16:0] fold1;
  logic [15:0] fold2;

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // stage 1: partial word sums of the target address
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      r1 <= in_req;
      sa <= 18'(in_req.hi[63:48]) + 18'(in_req.hi[47:32])
          + 18'(in_req.hi[31:16]) + 18'(in_req.hi[15:0]);
      sb <= 19'(in_req.lo[63:48]) + 19'(in_req.lo[47:32])
          + 19'(in_req.lo[31:16]) + 19'(in_req.lo[15:0])
          + 19'(in_req.lo[15:0])  + 19'(in_req.lo[23:16]);
    end
  end

  // stage 2: full sum with pseudo-header and fixed fields
  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      r2  <= r1;
      tot <= 20'(sa) + 20'(sb) + NS_CK_BASE;
    end
  end

  // stage 3: end-around carry fold and complement
  assign fold1 = {1'b0, tot[15:0]} + {13'd0, tot[19:16]};
  assign fold2 = fold1[15:0] + {15'd0, fold1[16]};

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      r3 <= r2;
      ck <= ~fold2;
    end
  end

  assign out_valid     = v3;
  assign out_frame.req = r3;
  assign out_frame.ck  = ck;

endmodule
`default_nettype wire

// File: sv/apfb_beat_gen.sv
`default_nettype none
module apfb_beat_gen import apfb_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [47:0]  mac,
  input  wire logic         in_valid,
  input  wire apfb_frame_t  in_frame,
  output logic              in_ready,
  output logic              strobe,
  output logic [63:0]       frame_word,
  output logic [3:0]        bytes_valid,
  output logic              last_beat
);

  logic        active;
  logic [3:0]  idx;
  logic [3:0]  idx_next;
  apfb_frame_t cur;
  logic [3:0]  last_idx;
  logic        at_last;
  logic [63:0] word_next;
  logic [3:0]  bytes_next;

  function automatic logic [63:0] beat_word(input logic cmd, input logic [3:0] k,
                                            input logic [47:0] m, input logic [63:0] hi,
                                            input logic [63:0] lo, input logic [15:0] ck);
    logic [63:0] w;
    begin
      w = 64'd0;
      if (cmd == CMD_ARP) begin
        case (k)
          4'd0: w = {48'hffff_ffff_ffff, m[47:32]};
          4'd1: w = {m[31:0], 32'h0806_0001};
          4'd2: w = {48'h0800_0604_0001, m[47:32]};
          4'd3: w = {m[31:0], 32'h0};
          4'd4: w = {48'h0, hi[63:48]};
          4'd5: w = {hi[47:32], 48'h0};
          default: w = 64'd0;
        endcase
      end else begin
        case (k)
          4'd0: w = {24'h3333ff, lo[23:0], m[47:32]};
          4'd1: w = {m[31:0], 32'h86dd_6000};
          4'd2: w = 64'h0000_0018_3aff_0000;
          4'd3: w = 64'd0;
          4'd4: w = 64'h0000_0000_0000_ff02;
          4'd5: w = 64'd0;
          4'd6: w = {24'h0001ff, lo[23:0], 16'h8700};
          4'd7: w = {ck, 32'h0, hi[63:48]};
          4'd8: w = {hi[47:0], lo[63:48]};
          4'd9: w = {lo[47:0], 16'h0};
          default: w = 64'd0;
        endcase
      end
      return w;
    end
  endfunction

  assign last_idx = (cur.req.cmd == CMD_NS) ? NS_LAST_IDX : ARP_LAST_IDX;
  assign at_last  = idx == last_idx;
  assign in_ready = !active || at_last;
  assign idx_next = idx + 4'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (in_ready) begin
      active <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cur <= in_frame;
      idx <= 4'd0;
    end else if (active) begin
      idx <= idx_next;
    end
  end

  assign word_next = beat_word(cur.req.cmd, idx, mac, cur.req.hi, cur.req.lo, cur.ck);
  assign bytes_next = !at_last ? FULL_BYTES
                    : (cur.req.cmd == CMD_NS) ? NS_LAST_BYTES : ARP_LAST_BYTES;

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= active;
    end
  end

  always_ff @(posedge clk) begin
    frame_word  <= word_next;
    bytes_valid <= bytes_next;
    last_beat   <= active && at_last;
  end

endmodule
`default_nettype wire

// File: sv/address_probe_frame_builder_unit.sv
// The first beat reaches the result ports after the request passes the three checksum
//   stages, the beat sequencer and the output register.
// Throughput: one beat per cycle from the beat sequencer: an ARP probe has 6
//   beats, a neighbor solicitation 10; up to three further requests queue in the pipe.
// Reset (rst, synchronous): pipe and sequencer empty, MAC address register cleared to 0.
// Results cannot be stalled; strobe marks each beat for one cycle.
`default_nettype none
module address_probe_frame_builder_unit import apfb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cmd,
  input  wire logic [63:0] target_hi,
  input  wire logic [63:0] target_lo,
  output logic             strobe,
  output logic [63:0]      frame_word,
  output logic [3:0]       bytes_valid,
  output logic             last_beat,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  logic [47:0] mac_addr;
  logic        pipe_ready;
  logic        frame_valid;
  logic        frame_ready;
  apfb_req_t   req;
  apfb_frame_t frame;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mac_addr <= 48'd0;
    end else if (psel && penable && pwrite && pready && !paddr[3]) begin
      mac_addr <= pwdata[47:0];
    end
  end

  assign prdata = paddr[3] ? 64'd0 : {16'd0, mac_addr};

  assign req.cmd = cmd;
  assign req.hi  = target_hi;
  assign req.lo  = target_lo;
  assign busy    = !pipe_ready;

  apfb_csum_pipe u_csum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .in_req    (req),
    .in_ready  (pipe_ready),
    .out_valid (frame_valid),
    .out_frame (frame),
    .out_ready (frame_ready)
  );

  apfb_beat_gen u_beat (
    .clk         (clk),
    .rst         (rst),
    .mac         (mac_addr),
    .in_valid    (frame_valid),
    .in_frame    (frame),
    .in_ready    (frame_ready),
    .strobe      (strobe),
    .frame_word  (frame_word),
    .bytes_valid (bytes_valid),
    .last_beat   (last_beat)
  );

  // beats of one frame are contiguous
  a_beats_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_beat |=> strobe)
    else $error("frame beats not contiguous");

  a_full_beats: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_beat |-> bytes_valid == FULL_BYTES)
    else $error("inner beat not full");

  a_last_bytes: assert property (@(posedge clk) disable iff (rst)
    strobe && last_beat |-> (bytes_valid == ARP_LAST_BYTES || bytes_valid == NS_LAST_BYTES))
    else $error("bad byte count on final beat");

  // a queued request at the pipe output starts right after a frame ends
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame_ready |=> ##1 strobe)
    else $error("queued frame not started");

endmodule
`default_nettype wire
